>>> design/highest_free_slot_allocator_unit_defines.svh
// assertion macros for the highest free slot allocator checker
`ifndef HIGHEST_FREE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define HIGHEST_FREE_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define HFSA_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hfsa check failed");

// next-cycle implication
`define HFSA_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hfsa check failed");

`endif

>>> design/hfsa_pkg.sv
// shared types and constants of the highest free slot allocator
`default_nettype none

package hfsa_pkg;

  localparam int SLOT_WORDS_DEF = 32;
  localparam int WORD_BITS_DEF  = 32;
  localparam int REQ_W          = 11;
  localparam logic [REQ_W-1:0] COUNT_MAX = {REQ_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OWN,
    ST_LOWER,
    ST_EMIT
  } hfsa_state_e;

  typedef struct packed {
    logic accept;
    logic decode;
    logic pick_own;
    logic read_lower;
    logic pick_lower;
    logic close;
    logic emit;
  } hfsa_cmd_t;

  typedef struct packed {
    logic closed;
    logic own_hit;
    logic lower_found;
    logic out_free;
  } hfsa_status_t;

endpackage

`default_nettype wire

>>> design/hfsa_ctrl.sv
// controller state machine of the highest free slot allocator
`default_nettype none

module hfsa_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire hfsa_pkg::hfsa_status_t status_i,
  output hfsa_pkg::hfsa_cmd_t         cmd_o
);
  import hfsa_pkg::*;

  hfsa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          // a closed block skips the search entirely
          state_d = status_i.closed ? ST_EMIT : ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_OWN;
      end
      ST_OWN: begin
        if (status_i.own_hit) begin
          cmd_o.pick_own = 1'b1;
          state_d        = ST_EMIT;
        end else if (status_i.lower_found) begin
          cmd_o.read_lower = 1'b1;
          state_d          = ST_LOWER;
        end else begin
          cmd_o.close = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_LOWER: begin
        cmd_o.pick_lower = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/hfsa_datapath.sv
// bitmap memory, word summary, search and result registers
`default_nettype none

module hfsa_datapath #(
  parameter int SLOT_WORDS = hfsa_pkg::SLOT_WORDS_DEF,
  parameter int WORD_BITS  = hfsa_pkg::WORD_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire hfsa_pkg::hfsa_cmd_t           cmd_i,
  output hfsa_pkg::hfsa_status_t             status_o,
  input  wire  [hfsa_pkg::REQ_W-1:0]         request_slot_i,
  input  wire                                last_request_i,
  input  wire                                out_stall_i,
  output logic                               out_valid_o,
  output logic                               granted_o,
  output logic [hfsa_pkg::REQ_W-1:0]         slot_taken_o,
  output logic [hfsa_pkg::REQ_W-1:0]         granted_total_o,
  output logic                               closed_o
);
  import hfsa_pkg::*;

  localparam int WA = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;
  localparam int BA = $clog2(WORD_BITS);
  localparam int SH = REQ_W + 1;
  localparam int PW = 2 * REQ_W + 2;
  localparam longint unsigned TOTAL = longint'(SLOT_WORDS) * longint'(WORD_BITS);
  localparam longint unsigned TOP_INT =
    (TOTAL < (64'd1 << REQ_W)) ? TOTAL - 1 : (64'd1 << REQ_W) - 1;
  localparam logic [REQ_W-1:0] TOP_IDX = TOP_INT[REQ_W-1:0];
  localparam int RECIP_INT = (2 ** SH) / WORD_BITS;
  localparam logic [PW-1:0] RECIP = PW'(RECIP_INT);
  localparam logic [PW-1:0] WB_L = PW'(WORD_BITS);
  localparam logic [REQ_W-1:0] WB_R = REQ_W'(WORD_BITS);

  logic [WORD_BITS-1:0] mem_q [SLOT_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic [SLOT_WORDS-1:0] valid_q, full_q;

  logic [REQ_W-1:0] s_q, west_q, cnt_q;
  logic             last_q, grant_q, miss_q, closed_q;
  logic [WA-1:0]    word_q;
  logic [BA-1:0]    bit_q;
  logic [WORD_BITS-1:0] wr_data_q;

  logic                 out_valid_q, granted_q, closed_out_q;
  logic [REQ_W-1:0]     slot_q, total_q;

  // accept: clamp the request and estimate its word by reciprocal
  logic [REQ_W-1:0] s_raw, s_sat;
  logic [PW-1:0]    est_prod;

  always_comb begin
    s_raw    = (request_slot_i == '0) ? '0 : request_slot_i - REQ_W'(1);
    s_sat    = (s_raw > TOP_IDX) ? TOP_IDX : s_raw;
    est_prod = PW'(s_sat) * RECIP;
  end

  // decode: correct the estimate by at most one word
  logic [PW-1:0]    back;
  logic [REQ_W-1:0] rem, word_dec, bit_dec;

  always_comb begin
    back = PW'(west_q) * WB_L;
    rem  = s_q - back[REQ_W-1:0];
    if (rem >= WB_R) begin
      word_dec = west_q + REQ_W'(1);
      bit_dec  = rem - WB_R;
    end else begin
      word_dec = west_q;
      bit_dec  = rem;
    end
  end

  // word search on the fetched word
  logic [WORD_BITS-1:0] eff, le_mask, free_own, free_sel;
  logic [BA-1:0]        pick_bit;

  always_comb begin
    eff = rdata_q & {WORD_BITS{valid_q[word_q]}};
    for (int i = 0; i < WORD_BITS; i++) begin
      le_mask[i] = (BA'(i) <= bit_q);
    end
    free_own = ~eff & le_mask;
    free_sel = cmd_i.pick_lower ? ~eff : free_own;
    pick_bit = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_sel[i]) begin
        pick_bit = BA'(i);
      end
    end
  end

  // highest non-full word below the request word
  logic [SLOT_WORDS-1:0] cand;
  logic [WA-1:0]         lower_idx;

  always_comb begin
    lower_idx = '0;
    for (int i = 0; i < SLOT_WORDS; i++) begin
      cand[i] = !(valid_q[i] && full_q[i]) && (WA'(i) < word_q);
      if (cand[i]) begin
        lower_idx = WA'(i);
      end
    end
  end

  logic          rd_en, wr_en;
  logic [WA-1:0] rd_addr;

  assign rd_en   = cmd_i.decode | cmd_i.read_lower;
  assign rd_addr = cmd_i.read_lower ? lower_idx : word_dec[WA-1:0];
  assign wr_en   = cmd_i.emit & grant_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[word_q] <= wr_data_q;
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s_q    <= s_sat;
      west_q <= est_prod[SH +: REQ_W];
      last_q <= last_request_i;
    end
    if (cmd_i.decode) begin
      word_q <= word_dec[WA-1:0];
      bit_q  <= bit_dec[BA-1:0];
    end
    if (cmd_i.read_lower) begin
      word_q <= lower_idx;
    end
    if (cmd_i.pick_own || cmd_i.pick_lower) begin
      bit_q     <= pick_bit;
      wr_data_q <= eff | (WORD_BITS'(1) << pick_bit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grant_q <= 1'b0;
      miss_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      grant_q <= 1'b0;
      miss_q  <= 1'b0;
    end else begin
      if (cmd_i.pick_own || cmd_i.pick_lower) begin
        grant_q <= 1'b1;
      end
      if (cmd_i.close) begin
        miss_q <= 1'b1;
      end
    end
  end

  // results of the item being emitted
  logic [PW-1:0]    taken_w;
  logic [REQ_W-1:0] cnt_next;
  logic             closed_next;

  always_comb begin
    taken_w     = PW'(word_q) * WB_L + PW'(bit_q) + PW'(1);
    cnt_next    = (grant_q && cnt_q != COUNT_MAX) ? cnt_q + REQ_W'(1) : cnt_q;
    closed_next = closed_q | miss_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      full_q   <= '0;
      cnt_q    <= '0;
      closed_q <= 1'b0;
    end else if (cmd_i.emit) begin
      if (last_q) begin
        // batch end clears summary, grant count and closed flag after the result is formed
        valid_q  <= '0;
        full_q   <= '0;
        cnt_q    <= '0;
        closed_q <= 1'b0;
      end else begin
        if (grant_q) begin
          valid_q[word_q] <= 1'b1;
          full_q[word_q]  <= &wr_data_q;
        end
        cnt_q    <= cnt_next;
        closed_q <= closed_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      granted_q    <= grant_q;
      slot_q       <= grant_q ? taken_w[REQ_W-1:0] : '0;
      total_q      <= cnt_next;
      closed_out_q <= closed_next;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_o       = granted_q;
  assign slot_taken_o    = slot_q;
  assign granted_total_o = total_q;
  assign closed_o        = closed_out_q;

  assign status_o.closed      = closed_q;
  assign status_o.own_hit     = |free_own;
  assign status_o.lower_found = |cand;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

>>> design/highest_free_slot_allocator_unit.sv
// top level of the highest free slot allocator
// an item is accepted in idle, then passes decode, own-word search and emit; a lower word
// is read between search and emit when needed, and a closed block goes from accept to emit
// one item at a time, and emit waits while a result stalls; an open block decodes,
// reads the bitmap and writes a grant back to it, a closed block skips the search
// reset clears bitmap summary, grant count and closed flag at once; no clear pass
`default_nettype none

module highest_free_slot_allocator_unit #(
  parameter int SLOT_WORDS = hfsa_pkg::SLOT_WORDS_DEF,
  parameter int WORD_BITS  = hfsa_pkg::WORD_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire  [hfsa_pkg::REQ_W-1:0]  request_slot_i,
  input  wire                         last_request_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic                        granted_o,
  output logic [hfsa_pkg::REQ_W-1:0]  slot_taken_o,
  output logic [hfsa_pkg::REQ_W-1:0]  granted_total_o,
  output logic                        closed_o
);
  import hfsa_pkg::*;

  hfsa_cmd_t    cmd;
  hfsa_status_t status;

  hfsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hfsa_datapath #(
    .SLOT_WORDS (SLOT_WORDS),
    .WORD_BITS  (WORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .request_slot_i  (request_slot_i),
    .last_request_i  (last_request_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .granted_o       (granted_o),
    .slot_taken_o    (slot_taken_o),
    .granted_total_o (granted_total_o),
    .closed_o        (closed_o)
  );

endmodule

`default_nettype wire

>>> design/hfsa_checker.sv
// port-level checker for the highest free slot allocator and its bind
`default_nettype none
`include "highest_free_slot_allocator_unit_defines.svh"

module hfsa_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_stall_o,
  input wire [hfsa_pkg::REQ_W-1:0]  request_slot_i,
  input wire                        last_request_i,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input wire                        granted_o,
  input wire [hfsa_pkg::REQ_W-1:0]  slot_taken_o,
  input wire [hfsa_pkg::REQ_W-1:0]  granted_total_o,
  input wire                        closed_o
);
  import hfsa_pkg::*;

  logic                 in_acc, in_wait, out_wait, out_grant, out_refuse;
  logic [REQ_W:0]       in_bus;
  logic [2*REQ_W+1:0]   out_bus;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_wait    = in_valid_i && in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign out_grant  = out_valid_o && granted_o;
  assign out_refuse = out_valid_o && !granted_o;
  assign in_bus     = {request_slot_i, last_request_i};
  assign out_bus    = {granted_o, slot_taken_o, granted_total_o, closed_o};

  // one item at a time: input closes right after an accept
  `HFSA_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)

  // stalled input item holds
  `HFSA_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_bus))

  // a refused item reports no slot
  `HFSA_ASSERT_IMP(a_refused_no_slot, clk_i, rst_ni, out_refuse, slot_taken_o == '0)

  // a grant never comes from a closed block
  `HFSA_ASSERT_IMP(a_grant_open, clk_i, rst_ni, out_grant, !closed_o && granted_total_o != '0)

  // stalled result holds
  `HFSA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_bus))

endmodule

bind highest_free_slot_allocator_unit hfsa_checker u_hfsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .request_slot_i  (request_slot_i),
  .last_request_i  (last_request_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .granted_o       (granted_o),
  .slot_taken_o    (slot_taken_o),
  .granted_total_o (granted_total_o),
  .closed_o        (closed_o)
);

`default_nettype wire
